[src/bmqb_pkg.sv]
// Package with the shared types, codes and defaults of the balanced multi-queue buffer.
package bmqb_pkg;

  localparam int NUM_QUEUES        = 4;
  localparam int QSEL_W            = 2;
  localparam int SEG_DEPTH_DEF     = 16;
  localparam int DATA_WIDTH_DEF    = 32;
  localparam int DATA_IO_W         = 32;
  localparam int CNT_IO_W          = 5;
  localparam int STATUS_W          = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                        operation;
    logic signed [DATA_IO_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic [QSEL_W-1:0]           queue_number;
    logic signed [DATA_IO_W-1:0] data_out;
    logic [CNT_IO_W-1:0]         count_zero;
    logic [CNT_IO_W-1:0]         count_one;
    logic [CNT_IO_W-1:0]         count_two;
    logic [CNT_IO_W-1:0]         count_three;
  } rsp_t;

endpackage

[src/bmqb_ram.sv]
// Generic single-write, single-read RAM with a registered, enabled read port.
module bmqb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/balanced_multi_queue_buffer.sv]
// Top level of the balanced multi-queue buffer: four ring-buffer queues in one shared RAM.
// Four queues share one RAM, each owning a fixed segment of SEG_DEPTH words used as a ring
// buffer. An insert goes to the least occupied queue and a delete pops the most occupied one,
// ties going to the lowest queue number; every request yields exactly one response carrying the
// status, the chosen queue, the popped word and all four counts after the step. The block takes
// one request per cycle when responses are taken as fast, and a response goes from its request
// transfer through the pending stage, beside the RAM read port's register, into the output
// register. Counts and pointers sit in flip-flops and are updated at the request transfer, so
// back-to-back requests see each other's effect at once. A word is only read after it was
// written, so the RAM needs no clearing after reset and requests are accepted right away.
module balanced_multi_queue_buffer #(
  parameter int SEG_DEPTH  = bmqb_pkg::SEG_DEPTH_DEF,
  parameter int DATA_WIDTH = bmqb_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bmqb_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bmqb_pkg::rsp_t rsp
);

  localparam int NQ     = bmqb_pkg::NUM_QUEUES;
  localparam int QW     = bmqb_pkg::QSEL_W;
  localparam int CNT_W  = $clog2(SEG_DEPTH + 1);
  localparam int PTR_W  = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
  localparam int WORDS  = NQ * SEG_DEPTH;
  localparam int ADDR_W = $clog2(WORDS);

  logic [CNT_W-1:0] cnt      [NQ];
  logic [CNT_W-1:0] cnt_next [NQ];
  logic [PTR_W-1:0] head     [NQ];
  logic [PTR_W-1:0] tail     [NQ];

  logic [QW-1:0]    least;
  logic [QW-1:0]    most;
  logic [QW-1:0]    sel;
  logic             is_del;
  logic             blocked;
  logic             acc;
  logic             do_push;
  logic             do_pop;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] ptr_inc;
  logic [ADDR_W-1:0] addr;
  logic [bmqb_pkg::STATUS_W-1:0] status_next;

  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                           p_valid;
  logic                           p_adv;
  logic                           p_pop;
  logic [bmqb_pkg::STATUS_W-1:0]  p_status;
  logic [QW-1:0]                  p_queue;
  logic [CNT_W-1:0]               p_cnt [NQ];

  always_comb begin
    least = '0;
    most  = '0;
    for (int i = 1; i < NQ; i++) begin
      if (cnt[i] < cnt[least]) begin
        least = QW'(i);
      end
      if (cnt[i] > cnt[most]) begin
        most = QW'(i);
      end
    end
  end

  assign is_del  = (req.operation == bmqb_pkg::OP_DELETE);
  assign sel     = is_del ? most : least;
  assign blocked = is_del ? (cnt[sel] == '0) : (cnt[sel] == CNT_W'(SEG_DEPTH));
  assign p_adv     = !rsp_valid || rsp_ready;
  assign req_ready = !p_valid || p_adv;
  assign acc     = req_valid && req_ready;
  assign do_push = acc && !is_del && !blocked;
  assign do_pop  = acc && is_del && !blocked;
  assign ptr     = is_del ? head[sel] : tail[sel];
  assign ptr_inc = (ptr == PTR_W'(SEG_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign addr    = ADDR_W'(sel) * ADDR_W'(SEG_DEPTH) + ADDR_W'(ptr);
  assign wr_data = DATA_WIDTH'($unsigned(req.data_in));

  always_comb begin
    if (!blocked) begin
      status_next = bmqb_pkg::ST_DONE;
    end else if (is_del) begin
      status_next = bmqb_pkg::ST_EMPTY;
    end else begin
      status_next = bmqb_pkg::ST_FULL;
    end
    for (int i = 0; i < NQ; i++) begin
      cnt_next[i] = cnt[i];
    end
    if (!blocked) begin
      if (is_del) begin
        cnt_next[sel] = cnt[sel] - 1'b1;
      end else begin
        cnt_next[sel] = cnt[sel] + 1'b1;
      end
    end
  end

  bmqb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_en   (do_pop),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NQ; i++) begin
        cnt[i]  <= '0;
        head[i] <= '0;
        tail[i] <= '0;
      end
      p_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        for (int i = 0; i < NQ; i++) begin
          cnt[i] <= cnt_next[i];
        end
      end
      if (do_push) begin
        tail[sel] <= ptr_inc;
      end
      if (do_pop) begin
        head[sel] <= ptr_inc;
      end
      if (acc) begin
        p_valid <= 1'b1;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
      if (p_valid && p_adv) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_pop    <= do_pop;
      p_status <= status_next;
      p_queue  <= sel;
      for (int i = 0; i < NQ; i++) begin
        p_cnt[i] <= cnt_next[i];
      end
    end
    if (p_valid && p_adv) begin
      rsp.status       <= p_status;
      rsp.queue_number <= p_queue;
      rsp.data_out     <= p_pop ? bmqb_pkg::DATA_IO_W'(rd_data) : '0;
      rsp.count_zero   <= bmqb_pkg::CNT_IO_W'(p_cnt[0]);
      rsp.count_one    <= bmqb_pkg::CNT_IO_W'(p_cnt[1]);
      rsp.count_two    <= bmqb_pkg::CNT_IO_W'(p_cnt[2]);
      rsp.count_three  <= bmqb_pkg::CNT_IO_W'(p_cnt[3]);
    end
  end

  // A full insert means the least occupied queue is full, so every queue is full.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == bmqb_pkg::ST_FULL |->
      rsp.count_zero == bmqb_pkg::CNT_IO_W'(SEG_DEPTH) &&
      rsp.count_one == bmqb_pkg::CNT_IO_W'(SEG_DEPTH) &&
      rsp.count_two == bmqb_pkg::CNT_IO_W'(SEG_DEPTH) &&
      rsp.count_three == bmqb_pkg::CNT_IO_W'(SEG_DEPTH))
    else $error("full status while some queue has room");

  // An empty delete only happens with every queue empty, and then picks queue zero.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == bmqb_pkg::ST_EMPTY |->
      rsp.queue_number == '0 && rsp.data_out == '0 &&
      rsp.count_zero == '0 && rsp.count_one == '0 &&
      rsp.count_two == '0 && rsp.count_three == '0)
    else $error("empty status while some queue holds data");

  // The popped word must survive in the RAM read register while the pending stage stalls.
  assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_adv |=> $stable(rd_data))
    else $error("RAM read data changed under a stalled pending transfer");

endmodule
